@@ hdl/lom_pkg.sv @@
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types, constants and codes of the limit order matcher.
// ----------------------------------------------------------------------------
package lom_pkg;

  localparam int ORDER_SLOTS = 64;
  localparam int PRICE_BITS  = 24;
  localparam int QTY_BITS    = 20;
  localparam int ID_BITS     = 32;
  localparam int SEQ_BITS    = 32;
  localparam int SLOT_BITS   = $clog2(ORDER_SLOTS);
  localparam int MAX_TRADES  = 63;
  localparam int TCNT_BITS   = 6;
  // side, price, qty, id, seq packed in one word
  localparam int ENTRY_BITS  = 1 + PRICE_BITS + QTY_BITS + ID_BITS + SEQ_BITS;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOT_FND = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  typedef struct packed {
    logic [1:0]            action;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   quantity;
    logic [ID_BITS-1:0]    order_id;
  } in_item_t;

  typedef struct packed {
    logic                  kind;
    logic [1:0]            status;
    logic [ID_BITS-1:0]    new_id;
    logic [PRICE_BITS-1:0] trade_price;
    logic [QTY_BITS-1:0]   trade_qty;
    logic [ID_BITS-1:0]    buy_id;
    logic [ID_BITS-1:0]    sell_id;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic [ID_BITS-1:0]    id;
    logic [SEQ_BITS-1:0]   seq;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_SCAN,
    S_FIND_LAST,
    S_ADD,
    S_BEST_SCAN,
    S_BEST_LAST,
    S_TRADE,
    S_UPD_BUY,
    S_UPD_SELL,
    S_ACK
  } state_t;

endpackage

@@ hdl/lom_ram.sv @@
// ----------------------------------------------------------------------------
// lom_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/lom_cmp.sv @@
// ----------------------------------------------------------------------------
// lom_cmp
// Shared compare unit: one slot against the running best bid and best ask.
// ----------------------------------------------------------------------------
module lom_cmp (
  input  logic              cand_ok,
  input  lom_pkg::entry_t   cand,
  input  logic              bid_ok,
  input  lom_pkg::entry_t   bid,
  input  logic              ask_ok,
  input  lom_pkg::entry_t   ask,
  output logic              take_bid,
  output logic              take_ask
);
  import lom_pkg::*;

  logic cand_buy;

  // price first, then earlier sequence on equal price
  always_comb begin
    cand_buy = (cand.side == SIDE_BUY);
    take_bid = cand_ok && cand_buy &&
               (!bid_ok || cand.price > bid.price ||
                (cand.price == bid.price && cand.seq < bid.seq));
    take_ask = cand_ok && !cand_buy &&
               (!ask_ok || cand.price < ask.price ||
                (cand.price == ask.price && cand.seq < ask.seq));
  end

endmodule

@@ hdl/limit_order_matcher.sv @@
// ----------------------------------------------------------------------------
// limit_order_matcher
// Single-symbol price-time priority order book with a sequenced slot scan.
// ----------------------------------------------------------------------------
// Sequence: a cancel or modify scans every slot for its id; an add stores the
// order, then scans for the best bid and ask once per trade and once more at
// the end; S_ACK then readies the acknowledgement, strobed the cycle after that.
// Throughput: one item at a time; busy falls as its acknowledgement is shown and
// the one-slot-per-cycle scan through the slot RAM's read port sets the rate.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset clears the valid bits, next id to one and next sequence to zero.
module limit_order_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lom_pkg::in_item_t  in_item,
  output logic               out_valid,
  output lom_pkg::out_item_t out_item
);
  import lom_pkg::*;

  state_t                 state_r, state_nxt;
  logic [ORDER_SLOTS-1:0] valid_r, valid_nxt;
  logic [ID_BITS-1:0]     next_id_r, next_id_nxt;
  logic [SEQ_BITS-1:0]    next_seq_r, next_seq_nxt;
  in_item_t               item_r, item_nxt;
  logic [SLOT_BITS:0]     idx_r, idx_nxt;
  logic [SLOT_BITS-1:0]   prev_r, prev_nxt;
  logic                   found_r, found_nxt;
  logic [SLOT_BITS-1:0]   hit_r, hit_nxt;
  entry_t                 hit_e_r, hit_e_nxt;
  logic                   bid_ok_r, bid_ok_nxt, ask_ok_r, ask_ok_nxt;
  logic [SLOT_BITS-1:0]   bid_i_r, bid_i_nxt, ask_i_r, ask_i_nxt;
  entry_t                 bid_r, bid_nxt, ask_r, ask_nxt;
  logic [QTY_BITS-1:0]    tq_r, tq_nxt;
  logic [TCNT_BITS-1:0]   tcnt_r, tcnt_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [ID_BITS-1:0]     nid_r, nid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  logic                   wr_en;
  logic [SLOT_BITS-1:0]   wr_addr, rd_addr;
  entry_t                 wr_data, rd_data;
  logic                   take_bid, take_ask;
  logic                   free_ok;
  logic [SLOT_BITS-1:0]   free_i;
  logic                   prev_valid;

  // slot payload store
  lom_ram #(.WIDTH(ENTRY_BITS), .DEPTH(ORDER_SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign prev_valid = valid_r[prev_r];

  // best-of-book compare against the slot read last cycle
  lom_cmp u_cmp (
    .cand_ok  (prev_valid),
    .cand     (rd_data),
    .bid_ok   (bid_ok_r),
    .bid      (bid_r),
    .ask_ok   (ask_ok_r),
    .ask      (ask_r),
    .take_bid (take_bid),
    .take_ask (take_ask)
  );

  // lowest free slot
  always_comb begin
    free_ok = 1'b0;
    free_i  = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_ok = 1'b1;
        free_i  = SLOT_BITS'(i);
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      next_id_r   <= ID_BITS'(1);
      next_seq_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      next_id_r   <= next_id_nxt;
      next_seq_r  <= next_seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    idx_r    <= idx_nxt;
    prev_r   <= prev_nxt;
    found_r  <= found_nxt;
    hit_r    <= hit_nxt;
    hit_e_r  <= hit_e_nxt;
    bid_ok_r <= bid_ok_nxt;
    ask_ok_r <= ask_ok_nxt;
    bid_i_r  <= bid_i_nxt;
    ask_i_r  <= ask_i_nxt;
    bid_r    <= bid_nxt;
    ask_r    <= ask_nxt;
    tq_r     <= tq_nxt;
    tcnt_r   <= tcnt_nxt;
    status_r <= status_nxt;
    nid_r    <= nid_nxt;
    out_r    <= out_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    next_id_nxt   = next_id_r;
    next_seq_nxt  = next_seq_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    hit_e_nxt     = hit_e_r;
    bid_ok_nxt    = bid_ok_r;
    ask_ok_nxt    = ask_ok_r;
    bid_i_nxt     = bid_i_r;
    ask_i_nxt     = ask_i_r;
    bid_nxt       = bid_r;
    ask_nxt       = ask_r;
    tq_nxt        = tq_r;
    tcnt_nxt      = tcnt_r;
    status_nxt    = status_r;
    nid_nxt       = nid_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = free_i;
    wr_data       = '0;
    rd_addr       = idx_r[SLOT_BITS-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt   = in_item;
          tcnt_nxt   = '0;
          nid_nxt    = '0;
          status_nxt = ST_OK;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          case (action_t'(in_item.action))
            ACT_ADD:    state_nxt = S_ADD;
            ACT_CANCEL,
            ACT_MODIFY: state_nxt = S_FIND_SCAN;
            default:    state_nxt = S_ACK;
          endcase
        end
      end

      // id lookup, one slot read a cycle, each compared in the cycle after its read
      S_FIND_SCAN: begin
        rd_addr = idx_r[SLOT_BITS-1:0];
        prev_nxt = idx_r[SLOT_BITS-1:0];
        if (idx_r != '0 && !found_r && prev_valid && rd_data.id == item_r.order_id) begin
          found_nxt = 1'b1;
          hit_nxt   = prev_r;
          hit_e_nxt = rd_data;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (SLOT_BITS+1)'(ORDER_SLOTS - 1)) state_nxt = S_FIND_LAST;
      end

      S_FIND_LAST: begin
        found_nxt = found_r;
        if (!found_r && prev_valid && rd_data.id == item_r.order_id) begin
          found_nxt = 1'b1;
          hit_nxt   = prev_r;
          hit_e_nxt = rd_data;
        end
        if (!found_nxt) begin
          status_nxt = ST_NOT_FND;
          state_nxt  = S_ACK;
        end else if (action_t'(item_r.action) == ACT_CANCEL) begin
          valid_nxt[hit_nxt] = 1'b0;
          state_nxt = S_ACK;
        end else if (item_r.quantity == '0) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_ACK;
        end else begin
          // modify: free the slot and re-add with the old side and price
          valid_nxt[hit_nxt] = 1'b0;
          item_nxt.side  = found_r ? hit_e_r.side  : rd_data.side;
          item_nxt.price = found_r ? hit_e_r.price : rd_data.price;
          state_nxt = S_ADD;
        end
      end

      // store the new order (sees the slot freed by a modify)
      S_ADD: begin
        if (item_r.price == '0 || item_r.quantity == '0) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_ACK;
        end else if (!free_ok) begin
          status_nxt = ST_FULL;
          state_nxt  = S_ACK;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = free_i;
          wr_data.side  = item_r.side;
          wr_data.price = item_r.price;
          wr_data.qty   = item_r.quantity;
          wr_data.id    = next_id_r;
          wr_data.seq   = next_seq_r;
          valid_nxt[free_i] = 1'b1;
          nid_nxt       = next_id_r;
          next_id_nxt   = next_id_r + 1'b1;
          next_seq_nxt  = next_seq_r + 1'b1;
          idx_nxt       = '0;
          bid_ok_nxt    = 1'b0;
          ask_ok_nxt    = 1'b0;
          state_nxt     = S_BEST_SCAN;
        end
      end

      // best bid and ask scan through the shared compare unit
      S_BEST_SCAN: begin
        rd_addr  = idx_r[SLOT_BITS-1:0];
        prev_nxt = idx_r[SLOT_BITS-1:0];
        if (idx_r != '0) begin
          if (take_bid) begin
            bid_ok_nxt = 1'b1; bid_i_nxt = prev_r; bid_nxt = rd_data;
          end
          if (take_ask) begin
            ask_ok_nxt = 1'b1; ask_i_nxt = prev_r; ask_nxt = rd_data;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (SLOT_BITS+1)'(ORDER_SLOTS - 1)) state_nxt = S_BEST_LAST;
      end

      S_BEST_LAST: begin
        if (take_bid) begin
          bid_ok_nxt = 1'b1; bid_i_nxt = prev_r; bid_nxt = rd_data;
        end
        if (take_ask) begin
          ask_ok_nxt = 1'b1; ask_i_nxt = prev_r; ask_nxt = rd_data;
        end
        state_nxt = S_TRADE;
      end

      // cross check and trade transfer
      S_TRADE: begin
        if (!bid_ok_r || !ask_ok_r || bid_r.price < ask_r.price) begin
          state_nxt = S_ACK;
        end else begin
          tq_nxt = (bid_r.qty < ask_r.qty) ? bid_r.qty : ask_r.qty;
          out_valid_nxt       = 1'b1;
          out_nxt.kind        = KIND_TRADE;
          out_nxt.status      = ST_OK;
          out_nxt.new_id      = nid_r;
          out_nxt.trade_price = (ask_r.seq < bid_r.seq) ? ask_r.price : bid_r.price;
          out_nxt.trade_qty   = tq_nxt;
          out_nxt.buy_id      = bid_r.id;
          out_nxt.sell_id     = ask_r.id;
          out_nxt.last        = 1'b0;
          tcnt_nxt            = tcnt_r + 1'b1;
          state_nxt           = S_UPD_BUY;
        end
      end

      // write back reduced quantities, one RAM write each
      S_UPD_BUY: begin
        wr_en       = 1'b1;
        wr_addr     = bid_i_r;
        wr_data     = bid_r;
        wr_data.qty = bid_r.qty - tq_r;
        if (wr_data.qty == '0) valid_nxt[bid_i_r] = 1'b0;
        state_nxt = S_UPD_SELL;
      end

      S_UPD_SELL: begin
        wr_en       = 1'b1;
        wr_addr     = ask_i_r;
        wr_data     = ask_r;
        wr_data.qty = ask_r.qty - tq_r;
        if (wr_data.qty == '0) valid_nxt[ask_i_r] = 1'b0;
        idx_nxt    = '0;
        bid_ok_nxt = 1'b0;
        ask_ok_nxt = 1'b0;
        if (tcnt_r == TCNT_BITS'(MAX_TRADES)) state_nxt = S_ACK;
        else state_nxt = S_BEST_SCAN;
      end

      // final acknowledgement transfer
      S_ACK: begin
        out_valid_nxt       = 1'b1;
        out_nxt.kind        = KIND_ACK;
        out_nxt.status      = status_r;
        out_nxt.new_id      = nid_r;
        out_nxt.trade_price = '0;
        out_nxt.trade_qty   = '0;
        out_nxt.buy_id      = '0;
        out_nxt.sell_id     = '0;
        out_nxt.last        = 1'b1;
        state_nxt           = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
